FILE: hw/rtl/wst_pkg.sv
`default_nettype none
package wst_pkg;

  localparam int unsigned SlotsDefault = 16;

  localparam int unsigned PidW   = 22;
  localparam int unsigned WkW    = 10;
  localparam int unsigned HdlW   = 11;
  localparam int unsigned ReqW   = 48;
  localparam int unsigned CntW   = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned LiveW  = 5;
  localparam int unsigned FreeW  = 15;
  localparam int unsigned UsedW  = 14;

  localparam logic [2:0] OpRegister = 3'd0;
  localparam logic [2:0] OpAnnounce = 3'd1;
  localparam logic [2:0] OpRemove   = 3'd2;
  localparam logic [2:0] OpUpdate   = 3'd3;
  localparam logic [2:0] OpHeavy    = 3'd4;
  localparam logic [2:0] OpIdle     = 3'd5;
  localparam logic [2:0] OpTotals   = 3'd6;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StBlocked = 2'd2;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [PidW-1:0]       process_id;
    logic [WkW-1:0]        max_workers;
    logic signed [HdlW-1:0] channel_handle;
    logic                  exit_abnormal;
    logic [WkW-1:0]        used_workers;
    logic [ReqW-1:0]       request_count;
    logic                  idle_flag;
    logic                  kill_pending;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [IdxW-1:0]       slot_index;
    logic signed [HdlW-1:0] released_handle;
    logic [LiveW-1:0]      live_children;
    logic signed [FreeW-1:0] free_workers;
    logic [UsedW-1:0]      used_total;
    logic [ReqW-1:0]       total_requests;
    logic                  table_empty;
    logic [CntW-1:0]       started_count;
    logic [CntW-1:0]       closed_count;
    logic [CntW-1:0]       crashed_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, clear scan state
    logic scan;    // examine the slot under the cursor
    logic commit;  // apply the operation, clear totals
    logic total;   // accumulate totals for the cursor slot
    logic finish;  // latch result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;    // cursor at final slot
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/wst_datapath.sv
`default_nettype none
module wst_datapath #(
  parameter int unsigned Slots = wst_pkg::SlotsDefault
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire wst_pkg::req_t     req_i,
  input  wire [wst_pkg::ReqW-1:0] thresh_i,
  input  wire wst_pkg::cmd_t     cmd_i,
  output wst_pkg::sts_t          sts_o,
  output wst_pkg::rsp_t          rsp_o
);
  import wst_pkg::*;

  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;

  logic [PidW-1:0] pid_q  [Slots];
  logic [WkW-1:0]  maxw_q [Slots];
  logic [WkW-1:0]  used_q [Slots];
  logic [ReqW-1:0] reqs_q [Slots];
  logic            idle_q [Slots];
  logic            kill_q [Slots];
  logic [HdlW-1:0] hdl_q  [Slots];

  logic [ReqW-1:0] retired_q;
  logic [CntW-1:0] starts_q, exits_q, crashes_q;

  req_t            r_q;
  logic [SW-1:0]   cur_q;
  logic            hit_q, free_q, have_q, kill_seen_q, any_live_q;
  logic [SW-1:0]   hit_idx_q, free_idx_q, best_idx_q;
  logic [ReqW-1:0] best_q;
  logic [1:0]      status_q;
  logic [SW-1:0]   idx_q;
  logic [HdlW-1:0] rel_q;
  logic [LiveW-1:0] live_q;
  logic [FreeW-1:0] off_q;
  logic [UsedW-1:0] usum_q;
  logic [ReqW-1:0] rsum_q;

  logic [PidW-1:0] c_pid;
  logic            c_live, c_kill, c_cand;
  logic [ReqW-1:0] c_bar;

  logic [1:0]      cm_status;
  logic [SW-1:0]   cm_idx;
  logic [HdlW-1:0] cm_rel;
  logic [ReqW-1:0] cm_retired;

  assign c_pid  = pid_q[cur_q];
  assign c_live = c_pid != '0;
  assign c_kill = c_live && kill_q[cur_q];
  assign c_bar  = have_q ? best_q : thresh_i;
  always_comb begin
    if (r_q.req_type == OpHeavy) begin
      c_cand = c_live && (reqs_q[cur_q] > c_bar);
    end else begin
      c_cand = c_live && used_q[cur_q] == '0 && idle_q[cur_q] &&
               (!have_q || reqs_q[cur_q] > best_q);
    end
  end

  // outcome of the operation once the first sweep is done
  always_comb begin
    cm_status  = StMiss;
    cm_idx     = '0;
    cm_rel     = '1;
    cm_retired = retired_q;
    case (r_q.req_type) inside
      OpRegister: if (r_q.process_id != '0 && free_q) begin
        cm_status = StOk; cm_idx = free_idx_q;
      end
      OpAnnounce: if (r_q.process_id != '0) cm_status = StOk;
      OpRemove: if (r_q.process_id != '0 && hit_q) begin
        cm_status  = StOk; cm_idx = hit_idx_q;
        cm_rel     = hdl_q[hit_idx_q];
        cm_retired = retired_q + reqs_q[hit_idx_q];
      end
      OpUpdate: if (r_q.process_id != '0 && hit_q) begin
        cm_status = StOk; cm_idx = hit_idx_q;
      end
      OpHeavy, OpIdle: begin
        if (kill_seen_q) begin
          cm_status = StBlocked;
        end else if (have_q) begin
          cm_status = StOk; cm_idx = best_idx_q;
        end
      end
      OpTotals: cm_status = StOk;
      default: cm_status = StMiss;
    endcase
  end

  assign sts_o.last = cur_q == SW'(Slots - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        pid_q[i]  <= '0;
        maxw_q[i] <= '0;
        used_q[i] <= '0;
        reqs_q[i] <= '0;
        idle_q[i] <= 1'b0;
        kill_q[i] <= 1'b0;
        hdl_q[i]  <= '1;
      end
      retired_q <= '0;
      starts_q  <= '0;
      exits_q   <= '0;
      crashes_q <= '0;
      cur_q     <= '0;
      hit_q <= 1'b0; free_q <= 1'b0; have_q <= 1'b0;
      kill_seen_q <= 1'b0; any_live_q <= 1'b0;
      status_q <= StMiss;
      idx_q <= '0;
      rel_q <= '1;
      live_q <= '0; off_q <= '0; usum_q <= '0; rsum_q <= '0;
      r_q <= '0;
      hit_idx_q <= '0; free_idx_q <= '0; best_idx_q <= '0; best_q <= '0;
      rsp_o <= '0;
    end else begin
      if (cmd_i.load) begin
        r_q <= req_i;
        cur_q <= '0;
        hit_q <= 1'b0; free_q <= 1'b0; have_q <= 1'b0; kill_seen_q <= 1'b0;
        hit_idx_q <= '0; free_idx_q <= '0; best_idx_q <= '0; best_q <= '0;
      end
      if (cmd_i.scan) begin
        if (!free_q && !c_live) begin
          free_q <= 1'b1; free_idx_q <= cur_q;
        end
        if (!hit_q && c_live && c_pid == r_q.process_id) begin
          hit_q <= 1'b1; hit_idx_q <= cur_q;
        end
        if (c_kill) kill_seen_q <= 1'b1;
        if (c_cand) begin
          have_q <= 1'b1; best_q <= reqs_q[cur_q]; best_idx_q <= cur_q;
        end
        cur_q <= sts_o.last ? '0 : cur_q + SW'(1);
      end
      if (cmd_i.commit) begin
        // apply the operation, clear totals for the second sweep
        status_q <= cm_status; idx_q <= cm_idx; rel_q <= cm_rel;
        retired_q <= cm_retired;
        live_q <= '0; off_q <= '0; usum_q <= '0; rsum_q <= cm_retired;
        any_live_q <= 1'b0;
        case (r_q.req_type)
          OpRegister: if (r_q.process_id != '0 && free_q) begin
            pid_q[free_idx_q]  <= r_q.process_id;
            maxw_q[free_idx_q] <= r_q.max_workers;
            used_q[free_idx_q] <= '0;
            reqs_q[free_idx_q] <= '0;
            kill_q[free_idx_q] <= 1'b0;
            idle_q[free_idx_q] <= 1'b1;
            hdl_q[free_idx_q]  <= r_q.channel_handle;
          end
          OpAnnounce: if (r_q.process_id != '0) begin
            starts_q <= starts_q + 1'b1;
          end
          OpRemove: if (r_q.process_id != '0 && hit_q) begin
            pid_q[hit_idx_q] <= '0;
            hdl_q[hit_idx_q] <= '1;
            exits_q <= exits_q + 1'b1;
            if (r_q.exit_abnormal) crashes_q <= crashes_q + 1'b1;
          end
          OpUpdate: if (r_q.process_id != '0 && hit_q) begin
            used_q[hit_idx_q] <= r_q.used_workers;
            reqs_q[hit_idx_q] <= r_q.request_count;
            idle_q[hit_idx_q] <= r_q.idle_flag;
            kill_q[hit_idx_q] <= r_q.kill_pending;
          end
          default: ;
        endcase
      end
      if (cmd_i.total) begin
        if (c_live) begin
          any_live_q <= 1'b1;
          if (!kill_q[cur_q]) begin
            live_q <= live_q + 1'b1;
            off_q  <= off_q + FreeW'(maxw_q[cur_q]) - FreeW'(used_q[cur_q]);
            usum_q <= usum_q + UsedW'(used_q[cur_q]);
            rsum_q <= rsum_q + reqs_q[cur_q];
          end
        end
        cur_q <= sts_o.last ? '0 : cur_q + SW'(1);
      end
      if (cmd_i.finish) begin
        rsp_o.status          <= status_q;
        rsp_o.slot_index      <= IdxW'(idx_q);
        rsp_o.released_handle <= rel_q;
        rsp_o.live_children   <= live_q;
        rsp_o.free_workers    <= off_q;
        rsp_o.used_total      <= usum_q;
        rsp_o.total_requests  <= rsum_q;
        rsp_o.table_empty     <= !any_live_q;
        rsp_o.started_count   <= starts_q;
        rsp_o.closed_count    <= exits_q;
        rsp_o.crashed_count   <= crashes_q;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/wst_ctrl.sv
`default_nettype none
module wst_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  wire wst_pkg::sts_t sts_i,
  output wst_pkg::cmd_t      cmd_o
);
  import wst_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_TOTAL  = 6'b001000,
    S_FIN    = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = S_TOTAL;
      end
      S_TOTAL: begin
        cmd_o.total = 1'b1;
        if (sts_i.last) state_d = S_FIN;
      end
      // latch the result the cycle after the last totals slot
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/worker_slot_table_unit.sv
`default_nettype none
// Worker slot table. Holds Slots process slots keyed by a nonzero process id and
// serves one request at a time: register, announce, remove, update, find heavy,
// find idle and totals. Every request gives one result carrying the status,
// the slot touched, the released handle and fresh table totals taken after the
// request. From acceptance to result a request goes through one sweep over the
// slots to locate ids, free slots and candidates, a commit step to apply the
// change, a second sweep to add up the totals and a finish step to latch the
// result; both sweeps read one slot a cycle. A new transaction is taken once
// the result has left.
// The request threshold may be written only while no request is in flight.
module worker_slot_table_unit #(
  parameter int unsigned Slots = wst_pkg::SlotsDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: req_type[2:0], process_id[24:3], max_workers[34:25],
  // channel_handle[45:35], exit_abnormal[46], used_workers[56:47],
  // request_count[104:57], idle_flag[105], kill_pending[106], zero fill
  input  wire  [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata, low bit up: status[1:0], slot_index[5:2], released_handle[16:6],
  // live_children[21:17], free_workers[36:22], used_total[50:37],
  // total_requests[98:51], table_empty[99], started_count[131:100],
  // closed_count[163:132], crashed_count[195:164], zero fill
  output logic [199:0] m_axis_tdata,
  input  wire          cfg_we_i,
  input  wire  [47:0]  cfg_wdata_i
);
  import wst_pkg::*;

  req_t            req;
  rsp_t            rsp;
  cmd_t            cmd;
  sts_t            sts;
  logic [ReqW-1:0] thresh_q;

  // hold the heavy-worker threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  assign req.req_type       = s_axis_tdata[2:0];
  assign req.process_id     = s_axis_tdata[24:3];
  assign req.max_workers    = s_axis_tdata[34:25];
  assign req.channel_handle = s_axis_tdata[45:35];
  assign req.exit_abnormal  = s_axis_tdata[46];
  assign req.used_workers   = s_axis_tdata[56:47];
  assign req.request_count  = s_axis_tdata[104:57];
  assign req.idle_flag      = s_axis_tdata[105];
  assign req.kill_pending   = s_axis_tdata[106];

  assign m_axis_tdata = {4'd0, rsp.crashed_count, rsp.closed_count, rsp.started_count,
                         rsp.table_empty, rsp.total_requests, rsp.used_total,
                         rsp.free_workers, rsp.live_children, rsp.released_handle,
                         rsp.slot_index, rsp.status};

  wst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wst_datapath #(.Slots(Slots)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .thresh_i (thresh_q),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .rsp_o    (rsp)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import wst_pkg::*;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainWait  = 80;
  localparam int unsigned RandItems  = 530;

  // one directed row: request plus optional typed expectation
  typedef struct {
    req_t        req;
    logic        has_exp;
    logic [1:0]  exp_status;
    logic [IdxW-1:0] exp_index;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [47:0]  cfg_wdata_i;

  worker_slot_table_unit #(.Slots(NumSlots)) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // shadow copy of the slot table
  logic [PidW-1:0]        tbl_pid  [NumSlots];
  logic [WkW-1:0]         tbl_max  [NumSlots];
  logic [WkW-1:0]         tbl_used [NumSlots];
  logic [ReqW-1:0]        tbl_reqs [NumSlots];
  logic                   tbl_idle [NumSlots];
  logic                   tbl_kill [NumSlots];
  logic [HdlW-1:0]        tbl_hdl  [NumSlots];
  logic [ReqW-1:0]        retired_sum;
  logic [CntW-1:0]        start_cnt, exit_cnt, crash_cnt;
  logic [ReqW-1:0]        heavy_bar;

  rsp_t  pending_rsp[$];
  logic  pending_chk[$];   // 1: also compare against typed directed expectation
  logic [1:0]      pending_st[$];
  logic [IdxW-1:0] pending_ix[$];
  int    errors;
  int    accepted_in, accepted_out;
  int    src_idle_pct, snk_idle_pct;
  bit    hold_sink;
  bit    done_flag;
  int    ops_seen[8];

  // process-id pool keeps well-formed sequences hitting live slots
  logic [PidW-1:0] pid_pool[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int slot_of(logic [PidW-1:0] pid);
    if (pid == '0) return -1;
    for (int i = 0; i < NumSlots; i++)
      if (tbl_pid[i] == pid) return i;
    return -1;
  endfunction

  // advance the shadow table by one request and return the response it yields
  function automatic rsp_t table_step(req_t rq);
    rsp_t r;
    int   s;
    bit   have, killed;
    logic [ReqW-1:0] best, bar;
    logic [FreeW-1:0] offered, used;
    logic [ReqW-1:0] reqs;
    r = '0;
    r.status = StMiss;
    r.released_handle = '1;
    have = 0;
    killed = 0;
    best = '0;
    case (rq.req_type)
      OpRegister: if (rq.process_id != '0) begin
        for (int i = 0; i < NumSlots; i++) if (tbl_pid[i] == '0) begin
          tbl_pid[i] = rq.process_id; tbl_max[i] = rq.max_workers;
          tbl_used[i] = '0; tbl_reqs[i] = '0; tbl_kill[i] = 0;
          tbl_idle[i] = 1; tbl_hdl[i] = rq.channel_handle;
          r.status = StOk; r.slot_index = i[IdxW-1:0];
          break;
        end
      end
      OpAnnounce: if (rq.process_id != '0) begin
        start_cnt++; r.status = StOk;
      end
      OpRemove: begin
        s = slot_of(rq.process_id);
        if (s >= 0) begin
          tbl_pid[s] = '0; r.released_handle = tbl_hdl[s]; tbl_hdl[s] = '1;
          retired_sum += tbl_reqs[s]; exit_cnt++;
          if (rq.exit_abnormal) crash_cnt++;
          r.status = StOk; r.slot_index = s[IdxW-1:0];
        end
      end
      OpUpdate: begin
        s = slot_of(rq.process_id);
        if (s >= 0) begin
          tbl_used[s] = rq.used_workers; tbl_reqs[s] = rq.request_count;
          tbl_idle[s] = rq.idle_flag; tbl_kill[s] = rq.kill_pending;
          r.status = StOk; r.slot_index = s[IdxW-1:0];
        end
      end
      OpHeavy, OpIdle: begin
        for (int i = 0; i < NumSlots; i++)
          if (tbl_pid[i] != '0 && tbl_kill[i]) killed = 1;
        if (killed) r.status = StBlocked;
        else begin
          for (int i = 0; i < NumSlots; i++) begin
            if (tbl_pid[i] == '0) continue;
            if (rq.req_type == OpHeavy) begin
              bar = have ? best : heavy_bar;
              if (tbl_reqs[i] > bar) begin
                best = tbl_reqs[i]; have = 1; r.slot_index = i[IdxW-1:0];
              end
            end else if (tbl_used[i] == '0 && tbl_idle[i]) begin
              if (!have || tbl_reqs[i] > best) begin
                best = tbl_reqs[i]; have = 1; r.slot_index = i[IdxW-1:0];
              end
            end
          end
          r.status = have ? StOk : StMiss;
        end
      end
      OpTotals: r.status = StOk;
      default: ;
    endcase
    offered = '0; used = '0; reqs = retired_sum; r.table_empty = 1;
    for (int i = 0; i < NumSlots; i++) if (tbl_pid[i] != '0) begin
      r.table_empty = 0;
      if (!tbl_kill[i]) begin
        r.live_children++;
        offered += FreeW'(tbl_max[i]);
        used += FreeW'(tbl_used[i]);
        reqs += tbl_reqs[i];
      end
    end
    r.free_workers = offered - used;
    r.used_total = used[UsedW-1:0];
    r.total_requests = reqs;
    r.started_count = start_cnt;
    r.closed_count = exit_cnt;
    r.crashed_count = crash_cnt;
    return r;
  endfunction

  function automatic logic [111:0] pack_req(req_t rq);
    return {5'b0, rq.kill_pending, rq.idle_flag, rq.request_count, rq.used_workers,
            rq.exit_abnormal, rq.channel_handle, rq.max_workers, rq.process_id,
            rq.req_type};
  endfunction

  function automatic rsp_t unpack_rsp(logic [199:0] d);
    rsp_t r;
    r.status = d[1:0];           r.slot_index = d[5:2];
    r.released_handle = d[16:6]; r.live_children = d[21:17];
    r.free_workers = d[36:22];   r.used_total = d[50:37];
    r.total_requests = d[98:51]; r.table_empty = d[99];
    r.started_count = d[131:100]; r.closed_count = d[163:132];
    r.crashed_count = d[195:164];
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()} >> 16;
  endfunction

  function automatic req_t rand_fields(logic [2:0] op);
    req_t rq;
    rq.req_type = op;
    rq.process_id = PidW'($urandom());
    rq.max_workers = WkW'($urandom());
    rq.channel_handle = HdlW'($urandom());
    rq.exit_abnormal = $urandom_range(0, 1);
    rq.used_workers = ($urandom_range(0, 2) == 0) ? '0 : WkW'($urandom());
    case ($urandom_range(0, 3))
      0: rq.request_count = '0;
      1: rq.request_count = 48'($urandom_range(0, 40));
      2: rq.request_count = '1 - 48'($urandom_range(0, 3));
      default: rq.request_count = rand48();
    endcase
    rq.idle_flag = $urandom_range(0, 1);
    rq.kill_pending = ($urandom_range(0, 4) == 0);
    return rq;
  endfunction

  // mostly register/update/remove on pooled ids, with noise and bad ids
  function automatic req_t rand_request();
    req_t rq;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 18)      rq = rand_fields(OpRegister);
    else if (pick < 26) rq = rand_fields(OpAnnounce);
    else if (pick < 40) rq = rand_fields(OpRemove);
    else if (pick < 64) rq = rand_fields(OpUpdate);
    else if (pick < 78) rq = rand_fields(OpHeavy);
    else if (pick < 90) rq = rand_fields(OpIdle);
    else if (pick < 97) rq = rand_fields(OpTotals);
    else                rq = rand_fields(3'd7);
    if ($urandom_range(0, 9) < 8 && pid_pool.size() > 0)
      rq.process_id = pid_pool[$urandom_range(0, pid_pool.size() - 1)];
    else if ($urandom_range(0, 5) == 0)
      rq.process_id = '0;
    if (rq.req_type == OpRegister && rq.process_id != '0 && slot_of(rq.process_id) < 0)
      pid_pool.push_back(rq.process_id);
    if (rq.req_type == OpUpdate && rq.kill_pending && $urandom_range(0, 1))
      rq.kill_pending = 0;   // keep finds reachable most of the time
    return rq;
  endfunction

  // tvalid stays up after a transaction unless the sender idles or pauses
  task automatic send_req(req_t rq, logic chk, logic [1:0] st, logic [IdxW-1:0] ix);
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_req(rq);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_rsp.push_back(table_step(rq));
    pending_chk.push_back(chk);
    pending_st.push_back(st);
    pending_ix.push_back(ix);
    ops_seen[rq.req_type]++;
    accepted_in++;
  endtask

  // wait for all results to drain and a quiet spell, then write the threshold
  task automatic drain_then_write(logic [47:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heavy_bar = val;
  endtask

  // result sink: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_sink = 0;
      end
      m_axis_tready <= !(snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct);
    end
  end

  // response checker
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_rsp(m_axis_tdata);
      accepted_out++;
      if (pending_rsp.size() == 0) begin
        $error("unexpected response %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (pending_chk.pop_front()) begin
          if (pending_st[0] != got.status) begin
            $error("status: typed %0d actual %0d", pending_st[0], got.status); errors++;
          end
          if (pending_ix[0] != got.slot_index) begin
            $error("slot_index: typed %0d actual %0d", pending_ix[0], got.slot_index);
            errors++;
          end
        end
        void'(pending_st.pop_front());
        void'(pending_ix.pop_front());
        if (want.status != got.status) begin
          $error("status: exp %0d act %0d", want.status, got.status); errors++; end
        if (want.slot_index != got.slot_index) begin
          $error("slot_index: exp %0d act %0d", want.slot_index, got.slot_index); errors++; end
        if (want.released_handle != got.released_handle) begin
          $error("released_handle: exp %0d act %0d", want.released_handle,
                 got.released_handle); errors++; end
        if (want.live_children != got.live_children) begin
          $error("live_children: exp %0d act %0d", want.live_children, got.live_children);
          errors++; end
        if (want.free_workers != got.free_workers) begin
          $error("free_workers: exp %0d act %0d", want.free_workers, got.free_workers);
          errors++; end
        if (want.used_total != got.used_total) begin
          $error("used_total: exp %0d act %0d", want.used_total, got.used_total); errors++; end
        if (want.total_requests != got.total_requests) begin
          $error("total_requests: exp %0d act %0d", want.total_requests,
                 got.total_requests); errors++; end
        if (want.table_empty != got.table_empty) begin
          $error("table_empty: exp %0d act %0d", want.table_empty, got.table_empty);
          errors++; end
        if (want.started_count != got.started_count) begin
          $error("started_count: exp %0d act %0d", want.started_count, got.started_count);
          errors++; end
        if (want.closed_count != got.closed_count) begin
          $error("closed_count: exp %0d act %0d", want.closed_count, got.closed_count);
          errors++; end
        if (want.crashed_count != got.crashed_count) begin
          $error("crashed_count: exp %0d act %0d", want.crashed_count, got.crashed_count);
          errors++; end
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (!done_flag) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit && !done_flag) begin
        $display("timeout: %0d idle cycles", quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t row;
    req_t     rq;
    logic [47:0] bars[4];
    errors = 0; accepted_in = 0; accepted_out = 0;
    hold_sink = 0; done_flag = 0;
    src_idle_pct = 23; snk_idle_pct = 82;
    foreach (ops_seen[k]) ops_seen[k] = 0;
    for (int i = 0; i < NumSlots; i++) begin
      tbl_pid[i] = '0; tbl_max[i] = '0; tbl_used[i] = '0; tbl_reqs[i] = '0;
      tbl_idle[i] = 0; tbl_kill[i] = 0; tbl_hdl[i] = '1;
    end
    retired_sum = '0; start_cnt = '0; exit_cnt = '0; crash_cnt = '0; heavy_bar = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed expectation only where obvious
    rq = '0;
    row.has_exp = 0; row.exp_status = StOk; row.exp_index = '0;
    rq.req_type = OpTotals;   row.req = rq; row.has_exp = 1; dir_rows.push_back(row);
    rq.req_type = OpHeavy;    row.req = rq; row.exp_status = StMiss; dir_rows.push_back(row);
    rq.req_type = OpRegister; row.req = rq; dir_rows.push_back(row);  // pid zero
    rq.req_type = OpRemove; rq.process_id = 22'h3FFFFF; row.req = rq; dir_rows.push_back(row);
    rq.req_type = 3'd7; row.req = rq; dir_rows.push_back(row);
    // fill every slot; max pid, extreme handles and worker counts
    for (int i = 0; i < NumSlots; i++) begin
      rq = '0;
      rq.req_type = OpRegister;
      rq.process_id = (i == 0) ? 22'h3FFFFF : PidW'(i + 1);
      rq.max_workers = (i % 2) ? 10'h3FF : 10'h0;
      rq.channel_handle = (i == 0) ? -11'sd1 : ((i == 1) ? 11'sd1023 : 11'(i));
      row.req = rq; row.has_exp = 1; row.exp_status = StOk; row.exp_index = i[IdxW-1:0];
      dir_rows.push_back(row);
    end
    rq.process_id = 22'h2; row.req = rq; row.exp_status = StMiss; row.exp_index = '0;
    dir_rows.push_back(row);  // table full
    row.has_exp = 0;
    rq = '0; rq.req_type = OpUpdate; rq.process_id = 22'h3FFFFF; rq.used_workers = 10'h3FF;
    rq.request_count = '1; rq.idle_flag = 1; row.req = rq; dir_rows.push_back(row);
    rq.req_type = OpAnnounce; row.req = rq; dir_rows.push_back(row);
    foreach (dir_rows[k])
      send_req(dir_rows[k].req, dir_rows[k].has_exp, dir_rows[k].exp_status,
               dir_rows[k].exp_index);

    // kill pending blocks both finds; then removal with abnormal exit
    rq = '0; rq.req_type = OpUpdate; rq.process_id = PidW'(5); rq.kill_pending = 1;
    send_req(rq, 0, StOk, '0);
    rq.req_type = OpHeavy; send_req(rq, 1, StBlocked, '0);
    rq.req_type = OpIdle;  send_req(rq, 1, StBlocked, '0);
    rq.req_type = OpRemove; rq.exit_abnormal = 1; send_req(rq, 1, StOk, IdxW'(4));
    rq.req_type = OpIdle;  send_req(rq, 0, StOk, '0);
    for (int i = 0; i < NumSlots; i++) if (tbl_pid[i] != '0) pid_pool.push_back(tbl_pid[i]);

    bars[0] = '1; bars[1] = 48'd20; bars[2] = rand48(); bars[3] = '0;
    for (int ph = 0; ph < 4; ph++) begin
      drain_then_write(bars[ph]);
      if (ph == 2) begin
        src_idle_pct = 82; snk_idle_pct = 23;
      end else if (ph == 3) begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end
      for (int n = 0; n < RandItems / 4; n++) begin
        if (ph == 1 && n == 10) hold_sink = 1;   // sink backs off, input must stall
        if (ph == 1 && n == 60) begin
          s_axis_tvalid <= 1'b0;
          while (pending_rsp.size() != 0) @(posedge clk_i);  // sender pauses for drain
        end
        // prune the id pool so it keeps a mix of live and stale ids
        if (pid_pool.size() > 40) void'(pid_pool.pop_front());
        send_req(rand_request(), 0, StOk, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    done_flag = 1;
    $display("covered %0d requests, %0d responses, thresholds 0, 20, random and max",
             accepted_in, accepted_out);
    $display("ops: reg %0d ann %0d rem %0d upd %0d heavy %0d idle %0d tot %0d bad %0d",
             ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4],
             ops_seen[5], ops_seen[6], ops_seen[7]);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
